>>> rtl/trial_division_prime_test_core_assert.svh
// Assertion macros used by the checker file.
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, dropped while reset is high.
`define TDPT_ASSERT_IMPLY(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, dropped while reset is high.
`define TDPT_ASSERT_NEXT(lbl, ant, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tdpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

   localparam int CandW = 31;
   localparam int DivW  = 16;
   localparam int SqW   = 32;
   localparam int CntW  = 5;

   localparam logic [CntW-1:0] LastBit      = CntW'(CandW - 1);
   localparam logic [DivW-1:0] FirstDivisor = DivW'(2);

   typedef struct packed {
      logic done;
      logic zero;
   } rem_status_type;

endpackage

`default_nettype wire

>>> rtl/tdpt_rem.sv
`timescale 1ns / 1ps
`default_nettype none

module tdpt_rem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [tdpt_pkg::CandW-1:0]  dividend,
   input  wire logic [tdpt_pkg::DivW-1:0]   divisor,
   output tdpt_pkg::rem_status_type         status
);

   typedef enum logic {
      REM_IDLE,
      REM_RUN
   } rem_state_type;

   rem_state_type                   state_ff;
   rem_state_type                   state_in;
   logic [tdpt_pkg::CandW-1:0]      dividend_ff;
   logic [tdpt_pkg::CandW-1:0]      dividend_in;
   logic [tdpt_pkg::DivW-1:0]       rem_ff;
   logic [tdpt_pkg::DivW-1:0]       rem_in;
   logic [tdpt_pkg::CntW-1:0]       cnt_ff;
   logic [tdpt_pkg::CntW-1:0]       cnt_in;
   tdpt_pkg::rem_status_type        status_ff;
   tdpt_pkg::rem_status_type        status_in;

   logic [tdpt_pkg::DivW:0]         trial;
   logic [tdpt_pkg::DivW:0]         div_ext;
   logic [tdpt_pkg::DivW-1:0]       rem_step;

   // one restoring step: bring down the next dividend bit
   assign trial    = {rem_ff, dividend_ff[tdpt_pkg::CandW-1]};
   assign div_ext  = {1'b0, divisor};
   assign rem_step = (trial >= div_ext) ? tdpt_pkg::DivW'(trial - div_ext)
                                        : tdpt_pkg::DivW'(trial);

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      cnt_in      = cnt_ff;
      status_in   = '0;
      case (state_ff)
         REM_IDLE: begin
            if (start) begin
               dividend_in = dividend;
               rem_in      = '0;
               cnt_in      = '0;
               state_in    = REM_RUN;
            end
         end
         REM_RUN: begin
            dividend_in = {dividend_ff[tdpt_pkg::CandW-2:0], 1'b0};
            rem_in      = rem_step;
            cnt_in      = cnt_ff + tdpt_pkg::CntW'(1);
            if (cnt_ff == tdpt_pkg::LastBit) begin
               status_in.done = 1'b1;
               status_in.zero = (rem_step == '0);
               state_in       = REM_IDLE;
            end
         end
         default: begin
            state_in = REM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= REM_IDLE;
         status_ff <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
   end

   assign status = status_ff;

endmodule

`default_nettype wire

>>> rtl/trial_division_prime_test_core.sv
// 0 and 1 are reported composite with no division. Larger candidates are tried against
// divisors from 2 upward in the bit-serial remainder unit (31 steps each) until one divides
// or its square exceeds the candidate. Worst case: the largest primes near 2^31, 46339 divisors.
// Throughput: one beat at a time; busy is low again in the cycle the result strobes.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle per beat.
// Reset (synchronous, active high) returns the core to idle and drops any beat in flight.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic [tdpt_pkg::CandW-1:0]  req_candidate,
   output      logic                        rsp_strobe,
   output      logic                        rsp_is_prime
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE
   } state_type;

   state_type                       state_ff;
   logic [tdpt_pkg::CandW-1:0]      cand_ff;
   logic [tdpt_pkg::DivW-1:0]       div_ff;
   logic [tdpt_pkg::SqW-1:0]        sq_ff;
   logic                            rem_start_ff;
   logic                            strobe_ff;
   logic                            prime_ff;

   tdpt_pkg::rem_status_type        rem_status;
   logic                            accept;
   logic                            sq_over;

   assign accept  = start && (state_ff == ST_IDLE);
   assign sq_over = sq_ff > {1'b0, cand_ff};

   tdpt_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start_ff),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .status   (rem_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_start_ff <= 1'b0;
         strobe_ff    <= 1'b0;
         prime_ff     <= 1'b0;
      end else begin
         rem_start_ff <= 1'b0;
         strobe_ff    <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cand_ff <= req_candidate;
                  div_ff  <= tdpt_pkg::FirstDivisor;
                  sq_ff   <= tdpt_pkg::SqW'(tdpt_pkg::FirstDivisor)
                             * tdpt_pkg::SqW'(tdpt_pkg::FirstDivisor);
                  if (req_candidate < tdpt_pkg::CandW'(tdpt_pkg::FirstDivisor)) begin
                     strobe_ff <= 1'b1;
                     prime_ff  <= 1'b0;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            ST_CHECK: begin
               if (sq_over) begin
                  strobe_ff <= 1'b1;
                  prime_ff  <= 1'b1;
                  state_ff  <= ST_IDLE;
               end else begin
                  rem_start_ff <= 1'b1;
                  state_ff     <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (rem_status.done) begin
                  if (rem_status.zero) begin
                     strobe_ff <= 1'b1;
                     prime_ff  <= 1'b0;
                     state_ff  <= ST_IDLE;
                  end else begin
                     // advance: (d+1)^2 = d^2 + 2d + 1
                     sq_ff    <= sq_ff + {{(tdpt_pkg::SqW - tdpt_pkg::DivW - 1){1'b0}},
                                          div_ff, 1'b1};
                     div_ff   <= div_ff + tdpt_pkg::DivW'(1);
                     state_ff <= ST_CHECK;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_is_prime = prime_ff;

endmodule

`default_nettype wire

>>> rtl/tdpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "trial_division_prime_test_core_assert.svh"

module tdpt_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic [tdpt_pkg::CandW-1:0]  req_candidate,
   input wire logic                        rsp_strobe,
   input wire logic                        rsp_is_prime
);

   logic take;

   assign take = start && !busy;

   `TDPT_ASSERT_NEXT(a_small_not_prime, take && (req_candidate < 2), rsp_strobe && !rsp_is_prime, "0 or 1 not reported as composite next cycle")
   `TDPT_ASSERT_IMPLY(a_two_three_prime, take && (req_candidate == 2 || req_candidate == 3), ##2 (rsp_strobe && rsp_is_prime), "2 or 3 not reported prime after two cycles")
   `TDPT_ASSERT_NEXT(a_busy_after_take, take && (req_candidate >= 2), busy && !rsp_strobe, "core not busy after taking a beat")
   `TDPT_ASSERT_IMPLY(a_strobe_idle, rsp_strobe, !busy, "result strobed while core still busy")

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (.*);

`default_nettype wire

>>> bench/trial_division_prime_test_core_test.sv
`timescale 1ns / 1ps

module trial_division_prime_test_core_test;

   typedef logic [tdpt_pkg::CandW-1:0] cand_type;

   typedef struct {
      cand_type candidate;
      bit       is_prime;
   } verdict_type;

   localparam cand_type LargestCand = '1;
   localparam int       SettleCycles = 40;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   cand_type req_candidate;
   logic     rsp_strobe;
   logic     rsp_is_prime;

   verdict_type verdict_q[$];
   int          error_count;
   int          items_sent;
   int          verdicts_checked;
   int          primes_seen;
   int          idle_pct;

   trial_division_prime_test_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_candidate (req_candidate),
      .rsp_strobe    (rsp_strobe),
      .rsp_is_prime  (rsp_is_prime)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #120_000_000;
      $display("trial_division_prime_test_core_test: done, errors");
      $finish;
   end

   function automatic bit prime_verdict(input cand_type n);
      longint divisor;
      longint value;
      value = longint'(n);
      if (value < 2) return 1'b0;
      for (divisor = 2; divisor * divisor <= value; divisor++) begin
         if (value % divisor == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic cand_type random_candidate();
      int unsigned kind;
      int unsigned factor;
      int unsigned multiple;
      kind = $urandom_range(9);
      if (kind < 6) return cand_type'($urandom_range(4095));
      if (kind < 8) return cand_type'($urandom_range(65535));
      // large composite with a small factor: exercises the top bits, finishes fast
      factor   = $urandom_range(2, 64);
      multiple = $urandom_range(1, 32'h7FFF_FFFF / factor);
      return cand_type'(factor * multiple);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   task automatic send_candidate(input cand_type n);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            start         <= 1'b0;
            req_candidate <= cand_type'($urandom);
         end
      end
      @(negedge clock);
      start         <= 1'b1;
      req_candidate <= n;
      do @(posedge clock); while (busy);
      verdict_q.push_back('{n, prime_verdict(n)});
      items_sent++;
   endtask

   always @(posedge clock) begin
      verdict_type due;
      if (!reset && rsp_strobe) begin
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, is_prime=%0b", rsp_is_prime));
         end else begin
            due = verdict_q.pop_front();
            verdicts_checked++;
            if (due.is_prime) primes_seen++;
            if (rsp_is_prime !== due.is_prime)
               report_mismatch($sformatf("candidate %0d: is_prime=%0b, want %0b",
                                         due.candidate, rsp_is_prime, due.is_prime));
         end
      end
   end

   task automatic test_corner_values();
      cand_type corners[$];
      corners = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 49, 97, 121, 65521, 65535};
      foreach (corners[i]) send_candidate(corners[i]);
   endtask

   task automatic test_largest_values();
      cand_type tops[$];
      tops = '{LargestCand - 1, cand_type'(32'h4000_0000), cand_type'(2147395600),
               cand_type'(2147302921), cand_type'(32'h3FFF_FFFF), LargestCand};
      foreach (tops[i]) send_candidate(tops[i]);
   endtask

   task automatic test_random_candidates(input int count);
      repeat (count) send_candidate(random_candidate());
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_candidate = '0;
      error_count   = 0;
      items_sent    = 0;
      verdicts_checked = 0;
      primes_seen   = 0;
      idle_pct      = 29;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_corner_values();
      test_largest_values();
      idle_pct = 29;
      test_random_candidates(28);
      idle_pct = 49;
      test_random_candidates(28);
      idle_pct = 0;
      test_random_candidates(22);

      @(negedge clock);
      start <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d candidates: corners, top of range, random small/medium/composite",
               items_sent);
      $display("checked %0d verdicts, %0d of them prime, %0d mismatches",
               verdicts_checked, primes_seen, error_count);
      if (error_count == 0)
         $display("trial_division_prime_test_core_test: done, clean");
      else
         $display("trial_division_prime_test_core_test: done, errors");
      $finish;
   end

endmodule
